// ----- rtl/sta_pkg.sv -----
// shared constants, command codes and control structs of the slot table allocator
package sta_pkg;

  localparam int SLOTS     = 256;
  localparam int TYPE_BITS = 8;
  localparam int CMD_W     = 3;
  localparam int ID_W      = 9;
  localparam int TAG_W     = 8;
  localparam int STAT_W    = 2;

  // cells are grouped for the two-level priority search
  localparam int GRP_W  = 16;
  localparam int GRP_N  = SLOTS / GRP_W;
  localparam int LIDX_W = $clog2(GRP_W);
  localparam int GIDX_W = $clog2(GRP_N);
  localparam int POS_W  = GIDX_W + LIDX_W;
  localparam int RD_W   = TYPE_BITS + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN     = 3'd0,
    CMD_DESTROY   = 3'd1,
    CMD_DIRTY     = 3'd2,
    CMD_READ      = 3'd3,
    CMD_NEXT      = 3'd4,
    CMD_NEXT_TYPE = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // command broadcast to every cell for the search
  typedef struct packed {
    cmd_t                 cmd;
    logic [ID_W-1:0]      id;
    logic [TYPE_BITS-1:0] tag;
  } scan_t;

  // table update broadcast at the end of an item
  typedef struct packed {
    logic                 en;
    cmd_t                 cmd;
    logic [ID_W-1:0]      id;
    logic [TYPE_BITS-1:0] tag;
  } wr_t;

endpackage

// ----- rtl/slot_table_allocator_scan_core.sv -----
// top level of the slot table allocator: command sequencing, cell row and result registers
//
// The table holds 256 slots, each a cell with its own type tag and dirty bit, cleared by
// reset. A command is taken when start is high and busy is low; its result appears on the
// out_ ports with out_valid high for one cycle, and cannot be held off. The result passes
// through the command register, the cells' match register, the per-group priority stage
// over sixteen cells, and the final stage over the sixteen groups that also updates the
// table and loads the result registers. busy drops in the cycle the result is shown, so a
// new command is taken only after the previous one has finished, whatever the command.
module slot_table_allocator_scan_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sta_pkg::CMD_W-1:0]     in_command,
  input  logic [sta_pkg::ID_W-1:0]      in_entity_id,
  input  logic [sta_pkg::TAG_W-1:0]     in_entity_type,
  output logic                          out_valid,
  output logic [sta_pkg::ID_W-1:0]      out_result_id,
  output logic [sta_pkg::TAG_W-1:0]     out_result_type,
  output logic                          out_result_dirty,
  output logic [sta_pkg::STAT_W-1:0]    out_status
);
  import sta_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_GRP,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  scan_t               scan_r;
  wr_t                 wr;

  logic [SLOTS-1:0]                cell_hit;
  logic [SLOTS-1:0][RD_W-1:0]      cell_rd;
  logic [GRP_N-1:0]                g_hit;
  logic [LIDX_W-1:0]               g_idx [GRP_N];
  logic [GRP_N-1:0][RD_W-1:0]      g_rd;

  logic                f_hit;
  logic [GIDX_W-1:0]   f_grp;
  logic [POS_W-1:0]    f_pos;
  logic [ID_W-1:0]     f_id;
  logic [RD_W-1:0]     f_rd;
  logic                id_ok;

  logic                out_valid_r;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [TAG_W-1:0]    res_type_r, res_type_nxt;
  logic                res_dirty_r, res_dirty_nxt;
  status_t             res_stat_r, res_stat_nxt;

  genvar k;
  generate
    for (k = 0; k < SLOTS; k++) begin : g_cell
      sta_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_id (ID_W'(k + 1)),
        .scan    (scan_r),
        .wr      (wr),
        .match_r (cell_hit[k]),
        .rd_r    (cell_rd[k])
      );
    end
    for (k = 0; k < GRP_N; k++) begin : g_grp
      sta_group u_grp (
        .clk   (clk),
        .hit   (cell_hit[k*GRP_W +: GRP_W]),
        .rd    (cell_rd[k*GRP_W +: GRP_W]),
        .hit_r (g_hit[k]),
        .idx_r (g_idx[k]),
        .rd_r  (g_rd[k])
      );
    end
  endgenerate

  // final search over the groups
  always_comb begin
    f_hit = 1'b0;
    f_grp = '0;
    f_rd  = '0;
    for (int i = GRP_N - 1; i >= 0; i--) begin
      if (g_hit[i]) begin
        f_hit = 1'b1;
        f_grp = GIDX_W'(i);
      end
    end
    for (int i = 0; i < GRP_N; i++) begin
      f_rd = f_rd | g_rd[i];
    end
    f_pos = {f_grp, g_idx[f_grp]};
    f_id  = ID_W'(f_pos) + ID_W'(1);
    id_ok = (scan_r.id != '0) && (scan_r.id <= ID_W'(SLOTS));
  end

  always_comb begin
    res_id_nxt    = '0;
    res_type_nxt  = '0;
    res_dirty_nxt = 1'b0;
    res_stat_nxt  = ST_OK;
    wr.en         = 1'b0;
    wr.cmd        = scan_r.cmd;
    wr.id         = scan_r.id;
    wr.tag        = scan_r.tag;
    case (scan_r.cmd)
      CMD_SPAWN: begin
        if (f_hit) begin
          res_id_nxt = f_id;
          wr.en      = 1'b1;
          wr.id      = f_id;
        end else begin
          res_stat_nxt = ST_FULL;
        end
      end
      CMD_DESTROY, CMD_DIRTY: begin
        if (id_ok) begin
          wr.en = 1'b1;
        end else begin
          res_stat_nxt = ST_RANGE;
        end
      end
      CMD_READ: begin
        if (id_ok) begin
          res_type_nxt  = TAG_W'(f_rd[TYPE_BITS-1:0]);
          res_dirty_nxt = f_rd[TYPE_BITS];
        end else begin
          res_stat_nxt = ST_RANGE;
        end
      end
      CMD_NEXT, CMD_NEXT_TYPE: begin
        res_id_nxt = f_hit ? f_id : ID_W'(SLOTS + 1);
      end
      default: begin
        res_id_nxt = '0;
      end
    endcase
    // table is only touched in the last stage
    if (state_r != S_FIN) begin
      wr.en = 1'b0;
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_CELL : S_IDLE;
      S_CELL:  state_nxt = S_GRP;
      S_GRP:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN);
    end
    if (state_r == S_IDLE && start) begin
      scan_r.cmd <= cmd_t'(in_command);
      scan_r.id  <= in_entity_id;
      scan_r.tag <= TYPE_BITS'(in_entity_type);
    end
    if (state_r == S_FIN) begin
      res_id_r    <= res_id_nxt;
      res_type_r  <= res_type_nxt;
      res_dirty_r <= res_dirty_nxt;
      res_stat_r  <= res_stat_nxt;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_id    = res_id_r;
  assign out_result_type  = res_type_r;
  assign out_result_dirty = res_dirty_r;
  assign out_status       = res_stat_r;

  a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("accepted item gave no result four cycles later");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_FIN)
    else $error("result strobe without a final stage");

  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_result_id == '0)
    else $error("full status with a slot id");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> state_r == S_FIN && wr.id != '0 && wr.id <= ID_W'(SLOTS))
    else $error("table write outside the final stage or to a bad id");

endmodule

// ----- rtl/sta_cell.sv -----
// one slot of the table: type tag, dirty bit and its registered match and read data
module sta_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sta_pkg::ID_W-1:0]    cell_id,
  input  sta_pkg::scan_t              scan,
  input  sta_pkg::wr_t                wr,
  output logic                        match_r,
  output logic [sta_pkg::RD_W-1:0]    rd_r
);
  import sta_pkg::*;

  logic [TYPE_BITS-1:0] type_r, type_nxt;
  logic                 dirty_r, dirty_nxt;
  logic                 match_nxt;
  logic [RD_W-1:0]      rd_nxt;
  logic                 sel;
  logic                 after;
  logic                 wr_hit;

  always_comb begin
    sel   = (scan.id == cell_id);
    after = (cell_id > scan.id);
    case (scan.cmd)
      CMD_SPAWN:     match_nxt = (type_r == '0);
      CMD_NEXT:      match_nxt = (type_r != '0) && after;
      CMD_NEXT_TYPE: match_nxt = (type_r == scan.tag) && after;
      CMD_READ:      match_nxt = sel;
      default:       match_nxt = 1'b0;
    endcase
    rd_nxt = sel ? {dirty_r, type_r} : '0;
  end

  always_comb begin
    wr_hit    = wr.en && (wr.id == cell_id);
    type_nxt  = type_r;
    dirty_nxt = dirty_r;
    if (wr_hit) begin
      case (wr.cmd)
        CMD_SPAWN: begin
          type_nxt  = wr.tag;
          dirty_nxt = 1'b0;
        end
        CMD_DESTROY: begin
          type_nxt  = '0;
          dirty_nxt = 1'b1;
        end
        CMD_DIRTY: begin
          // only an occupied slot gets marked
          if (type_r != '0) begin
            dirty_nxt = 1'b1;
          end
        end
        default: begin
          type_nxt  = type_r;
          dirty_nxt = dirty_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r  <= '0;
      dirty_r <= 1'b0;
    end else begin
      type_r  <= type_nxt;
      dirty_r <= dirty_nxt;
    end
    match_r <= match_nxt;
    rd_r    <= rd_nxt;
  end

endmodule

// ----- rtl/sta_group.sv -----
// registered lowest-index search and read-data merge over one group of cells
module sta_group (
  input  logic                                         clk,
  input  logic [sta_pkg::GRP_W-1:0]                    hit,
  input  logic [sta_pkg::GRP_W-1:0][sta_pkg::RD_W-1:0] rd,
  output logic                                         hit_r,
  output logic [sta_pkg::LIDX_W-1:0]                   idx_r,
  output logic [sta_pkg::RD_W-1:0]                     rd_r
);
  import sta_pkg::*;

  logic              hit_nxt;
  logic [LIDX_W-1:0] idx_nxt;
  logic [RD_W-1:0]   rd_nxt;

  always_comb begin
    hit_nxt = 1'b0;
    idx_nxt = '0;
    rd_nxt  = '0;
    // walk down so the lowest set bit wins
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_nxt = 1'b1;
        idx_nxt = LIDX_W'(i);
      end
    end
    for (int i = 0; i < GRP_W; i++) begin
      rd_nxt = rd_nxt | rd[i];
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    idx_r <= idx_nxt;
    rd_r  <= rd_nxt;
  end

endmodule

// ----- test/slot_table_allocator_scan_core_tb.sv -----
// self-checking bench for the slot table allocator: directed table, fill run and random command mix
module slot_table_allocator_scan_core_tb;
  import sta_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_B = 3'd7;
  localparam int MAX_CYCLES  = 200000;
  localparam int RAND_ITEMS  = 800;
  localparam int PHASE_LEN   = 120;
  localparam int DRAIN_WAIT  = 10;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  rtype;
    logic              dirty;
    logic [STAT_W-1:0] status;
  } slot_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
    logic             fixed;
    slot_reply_t      want;
  } plan_row_t;

  localparam int PLAN_N = 26;
  localparam plan_row_t PLAN [PLAN_N] = '{
    '{CMD_READ,      9'd1,   8'd0,   1'b1, '{9'd0,   8'd0,   1'b0, ST_OK}},
    '{CMD_READ,      9'd256, 8'd0,   1'b1, '{9'd0,   8'd0,   1'b0, ST_OK}},
    '{CMD_READ,      9'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   1'b0, ST_RANGE}},
    '{CMD_READ,      9'd257, 8'd0,   1'b1, '{9'd0,   8'd0,   1'b0, ST_RANGE}},
    '{CMD_DESTROY,   9'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   1'b0, ST_RANGE}},
    '{CMD_DIRTY,     9'd257, 8'd255, 1'b1, '{9'd0,   8'd0,   1'b0, ST_RANGE}},
    '{CMD_NEXT,      9'd0,   8'd0,   1'b1, '{9'd257, 8'd0,   1'b0, ST_OK}},
    '{CMD_NEXT_TYPE, 9'd0,   8'd0,   1'b1, '{9'd1,   8'd0,   1'b0, ST_OK}},
    '{CMD_NEXT,      9'd256, 8'd0,   1'b1, '{9'd257, 8'd0,   1'b0, ST_OK}},
    '{CMD_NEXT_TYPE, 9'd257, 8'd0,   1'b1, '{9'd257, 8'd0,   1'b0, ST_OK}},
    '{CMD_SPAWN,     9'd0,   8'd255, 1'b1, '{9'd1,   8'd0,   1'b0, ST_OK}},
    // tag zero leaves the slot free
    '{CMD_SPAWN,     9'd0,   8'd0,   1'b1, '{9'd2,   8'd0,   1'b0, ST_OK}},
    '{CMD_SPAWN,     9'd511, 8'd1,   1'b0, '0},
    '{CMD_READ,      9'd2,   8'd0,   1'b0, '0},
    '{CMD_DIRTY,     9'd1,   8'd0,   1'b0, '0},
    '{CMD_READ,      9'd1,   8'd0,   1'b1, '{9'd0,   8'd255, 1'b1, ST_OK}},
    // dirty on a free slot is ignored
    '{CMD_DIRTY,     9'd3,   8'd0,   1'b0, '0},
    '{CMD_READ,      9'd3,   8'd0,   1'b0, '0},
    // destroy of a free slot still marks it dirty
    '{CMD_DESTROY,   9'd200, 8'd0,   1'b0, '0},
    '{CMD_READ,      9'd200, 8'd0,   1'b1, '{9'd0,   8'd0,   1'b1, ST_OK}},
    '{CMD_NEXT_TYPE, 9'd0,   8'd1,   1'b0, '0},
    '{CMD_NEXT,      9'd1,   8'd0,   1'b0, '0},
    '{CMD_UNDEF_A,   9'd256, 8'd255, 1'b1, '{9'd0,   8'd0,   1'b0, ST_OK}},
    '{CMD_UNDEF_B,   9'd511, 8'd255, 1'b1, '{9'd0,   8'd0,   1'b0, ST_OK}},
    '{CMD_DESTROY,   9'd1,   8'd0,   1'b0, '0},
    '{CMD_SPAWN,     9'd0,   8'd170, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_command;
  logic [ID_W-1:0]   in_entity_id;
  logic [TAG_W-1:0]  in_entity_type;
  logic              out_valid;
  logic [ID_W-1:0]   out_result_id;
  logic [TAG_W-1:0]  out_result_type;
  logic              out_result_dirty;
  logic [STAT_W-1:0] out_status;

  slot_table_allocator_scan_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_entity_id     (in_entity_id),
    .in_entity_type   (in_entity_type),
    .out_valid        (out_valid),
    .out_result_id    (out_result_id),
    .out_result_type  (out_result_type),
    .out_result_dirty (out_result_dirty),
    .out_status       (out_status)
  );

  logic [TYPE_BITS-1:0] tag_mem   [1:SLOTS];
  logic                 dirty_mem [1:SLOTS];
  slot_reply_t          due_q [$];
  bit                   failed;
  int                   cycle_cnt = 0;
  int                   burst_left;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // table model: one reply per command, updates the shadow table
  function automatic slot_reply_t apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                                logic [TAG_W-1:0] tag);
    slot_reply_t r;
    bit          id_ok;
    int          i;
    r     = '0;
    id_ok = (id >= 1) && (id <= SLOTS);
    case (cmd)
      CMD_SPAWN: begin
        r.status = ST_FULL;
        for (i = 1; i <= SLOTS; i++) begin
          if (tag_mem[i] == '0) begin
            tag_mem[i]   = tag[TYPE_BITS-1:0];
            dirty_mem[i] = 1'b0;
            r.id         = ID_W'(i);
            r.status     = ST_OK;
            break;
          end
        end
      end
      CMD_DESTROY: begin
        if (!id_ok) begin
          r.status = ST_RANGE;
        end else begin
          tag_mem[id]   = '0;
          dirty_mem[id] = 1'b1;
        end
      end
      CMD_DIRTY: begin
        if (!id_ok) r.status = ST_RANGE;
        else if (tag_mem[id] != '0) dirty_mem[id] = 1'b1;
      end
      CMD_READ: begin
        if (!id_ok) begin
          r.status = ST_RANGE;
        end else begin
          r.rtype = TAG_W'(tag_mem[id]);
          r.dirty = dirty_mem[id];
        end
      end
      CMD_NEXT, CMD_NEXT_TYPE: begin
        r.id = ID_W'(SLOTS + 1);
        for (i = int'(id) + 1; i <= SLOTS; i++) begin
          if ((cmd == CMD_NEXT) ? (tag_mem[i] != '0) : (tag_mem[i] == tag[TYPE_BITS-1:0])) begin
            r.id = ID_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // check every strobed result against the oldest pending reply
  always @(posedge clk) begin
    slot_reply_t w;
    if (rst_n && out_valid) begin
      if (due_q.size() == 0) begin
        $error("unexpected result: id %0d type %0d dirty %0d status %0d", out_result_id,
               out_result_type, out_result_dirty, out_status);
        failed = 1'b1;
      end else begin
        w = due_q.pop_front();
        if (out_result_id !== w.id) begin
          $error("result_id: expected %0d, got %0d", w.id, out_result_id);
          failed = 1'b1;
        end
        if (out_result_type !== w.rtype) begin
          $error("result_type: expected %0d, got %0d", w.rtype, out_result_type);
          failed = 1'b1;
        end
        if (out_result_dirty !== w.dirty) begin
          $error("result_dirty: expected %0d, got %0d", w.dirty, out_result_dirty);
          failed = 1'b1;
        end
        if (out_status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  // present one item and hold it until taken; start stays high afterwards
  task automatic issue(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
                       logic fixed, slot_reply_t want);
    slot_reply_t got;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start          <= 1'b1;
    in_command     <= cmd;
    in_entity_id   <= id;
    in_entity_type <= tag;
    do @(posedge clk); while (busy !== 1'b0);
    got = apply_command(cmd, id, tag);
    due_q.push_back(fixed ? want : got);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return ID_W'(SLOTS + 1);
    if (r < 14) return ID_W'(SLOTS);
    if (r < 16) return ID_W'($urandom_range(0, 511));
    return ID_W'($urandom_range(1, SLOTS));
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 70) return TAG_W'($urandom_range(1, 6));
    return TAG_W'($urandom_range(0, 255));
  endfunction

  task automatic random_item(bit growing);
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
    r   = $urandom_range(0, 99);
    id  = pick_id();
    tag = pick_tag();
    if (r < (growing ? 40 : 12)) cmd = CMD_SPAWN;
    else if (r < 52) cmd = CMD_DESTROY;
    else if (r < 62) cmd = CMD_DIRTY;
    else if (r < 78) cmd = CMD_READ;
    else if (r < 88) cmd = CMD_NEXT;
    else if (r < 99) cmd = CMD_NEXT_TYPE;
    else cmd = ($urandom_range(0, 1) != 0) ? CMD_UNDEF_A : CMD_UNDEF_B;
    // in shrink phases most spawns turn into destroys
    if (!growing && r >= 12 && r < 40) cmd = CMD_DESTROY;
    if (cmd == CMD_NEXT_TYPE && $urandom_range(0, 1) != 0)
      tag = TAG_W'(tag_mem[$urandom_range(1, SLOTS)]);
    if ((cmd == CMD_NEXT || cmd == CMD_NEXT_TYPE) && $urandom_range(0, 3) == 0)
      id = ID_W'($urandom_range(0, 20));
    issue(cmd, id, tag, 1'b0, '0);
  endtask

  initial begin
    int  i;
    int  n;
    bit  growing;
    failed         = 1'b0;
    burst_left     = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_command     <= '0;
    in_entity_id   <= '0;
    in_entity_type <= '0;
    for (i = 1; i <= SLOTS; i++) begin
      tag_mem[i]   = '0;
      dirty_mem[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    for (i = 0; i < PLAN_N; i++)
      issue(PLAN[i].cmd, PLAN[i].id, PLAN[i].tag, PLAN[i].fixed, PLAN[i].want);
    drain_results();

    // fill the table and run past full
    for (i = 0; i < 262; i++)
      issue(CMD_SPAWN, ID_W'($urandom_range(0, 511)), TAG_W'($urandom_range(1, 255)), 1'b0, '0);
    drain_results();

    growing = 1'b0;
    n       = 262;
    while (n < RAND_ITEMS) begin
      random_item(growing);
      n++;
      if (n % PHASE_LEN == 0) begin
        growing = !growing;
        drain_results();
      end
    end

    start <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed && due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- slot_table_allocator_scan_core.f -----
rtl/sta_pkg.sv
rtl/sta_cell.sv
rtl/sta_group.sv
rtl/slot_table_allocator_scan_core.sv
test/slot_table_allocator_scan_core_tb.sv
